@@ hdl/pci_config_scan_sequencer_top_defines.svh @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - assertion macros
// Shared property wrappers for the scan sequencer checks.
// ---------------------------------------------------------------------------
`ifndef PCI_CONFIG_SCAN_SEQUENCER_TOP_DEFINES_SVH
`define PCI_CONFIG_SCAN_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PCSS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define PCSS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pcss_pkg.sv @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - package
// Types, constants and result builders shared by the scan sequencer files.
// ---------------------------------------------------------------------------
package pcss_pkg;

   localparam int NUM_BUSES = 8;
   localparam int BUS_CNT_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
   localparam logic [BUS_CNT_W-1:0] BUS_LAST = BUS_CNT_W'(NUM_BUSES - 1);

   localparam logic [4:0] SLOT_LAST = 5'd31;
   localparam logic [2:0] FUNC_LAST = 3'd7;

   localparam logic [7:0]  MAX_DEVICES_RESET = 8'hFF;
   localparam logic [15:0] VENDOR_NONE       = 16'hFFFF;
   // multi-function flag: bit 7 of the header-type byte of the header word
   localparam int          MULTI_FUNC_BIT    = 23;

   localparam logic [7:0] OFFSET_ID    = 8'h00;
   localparam logic [7:0] OFFSET_CLASS = 8'h08;
   localparam logic [7:0] OFFSET_HDR   = 8'h0C;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ID,
      PH_CLASS,
      PH_HDR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic {
      REQ_START    = 1'b0,
      REQ_RESPONSE = 1'b1
   } req_kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  bus_num;
      logic [4:0]  slot_num;
      logic [2:0]  func_num;
      logic [7:0]  reg_offset;
      logic [15:0] vendor_id;
      logic [15:0] device_id;
      logic [7:0]  revision;
      logic [7:0]  prog_if;
      logic [7:0]  sub_class;
      logic [7:0]  class_code;
      logic        last;
   } rsp_item_type;

   // low three bits of the bus counter, zero-extended for narrow counters
   function automatic logic [2:0] bus_field(input logic [BUS_CNT_W-1:0] bus);
      logic [8:0] wide;
      wide = 9'(bus);
      return wide[2:0];
   endfunction

   function automatic rsp_item_type read_item(input logic [BUS_CNT_W-1:0] bus,
                                              input logic [4:0] slot,
                                              input logic [2:0] func,
                                              input logic [7:0] offset);
      rsp_item_type item;
      item            = '0;
      item.kind       = KIND_READ;
      item.bus_num    = bus_field(bus);
      item.slot_num   = slot;
      item.func_num   = func;
      item.reg_offset = offset & 8'hFC;
      return item;
   endfunction

   function automatic rsp_item_type done_item();
      rsp_item_type item;
      item      = '0;
      item.kind = KIND_DONE;
      return item;
   endfunction

endpackage

@@ hdl/pcss_req_if.sv @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - request channel
// Valid/ready channel carrying start commands and read responses.
// ---------------------------------------------------------------------------
interface pcss_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] read_data;

   modport source (output valid, output req_type, output read_data, input ready);
   modport sink   (input valid, input req_type, input read_data, output ready);
endinterface

@@ hdl/pcss_rsp_if.sv @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - response channel
// Valid/ready channel carrying read requests, device records and scan done.
// ---------------------------------------------------------------------------
interface pcss_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  bus_num;
   logic [4:0]  slot_num;
   logic [2:0]  func_num;
   logic [7:0]  reg_offset;
   logic [15:0] vendor_id;
   logic [15:0] device_id;
   logic [7:0]  revision;
   logic [7:0]  prog_if;
   logic [7:0]  sub_class;
   logic [7:0]  class_code;
   logic        last;

   modport source (output valid, output kind, output bus_num, output slot_num,
                   output func_num, output reg_offset, output vendor_id,
                   output device_id, output revision, output prog_if,
                   output sub_class, output class_code, output last,
                   input ready);
   modport sink   (input valid, input kind, input bus_num, input slot_num,
                   input func_num, input reg_offset, input vendor_id,
                   input device_id, input revision, input prog_if,
                   input sub_class, input class_code, input last,
                   output ready);
endinterface

@@ hdl/pci_config_scan_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - top level
// Brute-force bus/slot/function walk driven by configuration read responses.
// ---------------------------------------------------------------------------
// A start transaction resets the walk and issues the first ID read (or done
// if max_devices is 0); every response transaction decides the next read, a
// device record or scan done in the same cycle it is accepted, and results go
// to a four-entry result buffer that is read out one per cycle while rsp_chan
// is ready. req_chan takes one transaction per cycle while the buffer has
// room for two results; a class-word response yields two results (record plus
// next read or done). In a real system the round trip of each configuration
// read outside the block sets the scan speed. max_devices is to be written
// through csr_write_enable/csr_write_data by the user only while no scan is
// running; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module pci_config_scan_sequencer_top (
   input  logic       clock,
   input  logic       reset,
   pcss_req_if.sink   req_chan,
   pcss_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import pcss_pkg::*;

   `include "pci_config_scan_sequencer_top_defines.svh"

   phase_type              phase_ff, phase_in;
   logic [BUS_CNT_W-1:0]   bus_ff, bus_in;
   logic [4:0]             slot_ff, slot_in;
   logic [2:0]             func_ff, func_in;
   logic [31:0]            held_ff, held_in;
   logic [7:0]             found_ff, found_in;
   logic [7:0]             max_devices_ff;

   rsp_item_type           fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]      fill_ff;

   logic                   req_accept, rsp_pop;
   logic [1:0]             push_cnt;
   rsp_item_type           item0, item1;

   logic [7:0]             found_inc, limit_cnt;
   logic                   limit_hit, adv_skip, adv_wrap;
   logic [BUS_CNT_W-1:0]   adv_bus;
   logic [4:0]             adv_slot;
   logic [2:0]             adv_func;
   rsp_item_type           adv_item;
   phase_type              adv_phase;

   assign req_chan.ready = (fill_ff <= FILL_W'(FIFO_DEPTH - 2));
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_pop        = rsp_chan.valid && rsp_chan.ready;

   // next position and the result of moving there
   always_comb begin
      found_inc = found_ff + 8'd1;
      limit_cnt = (phase_ff == PH_CLASS) ? found_inc : found_ff;
      limit_hit = (limit_cnt >= max_devices_ff);

      unique case (phase_ff)
         PH_ID:   adv_skip = (func_ff == 3'd0);
         PH_HDR:  adv_skip = !req_chan.read_data[MULTI_FUNC_BIT];
         default: adv_skip = 1'b0;
      endcase

      adv_bus  = bus_ff;
      adv_slot = slot_ff;
      adv_func = func_ff;
      adv_wrap = 1'b0;
      if (!adv_skip && func_ff != FUNC_LAST) begin
         adv_func = func_ff + 3'd1;
      end else begin
         adv_func = 3'd0;
         adv_slot = slot_ff + 5'd1;
         if (slot_ff == SLOT_LAST) begin
            if (bus_ff == BUS_LAST) begin
               adv_bus  = '0;
               adv_wrap = 1'b1;
            end else begin
               adv_bus = bus_ff + BUS_CNT_W'(1);
            end
         end
      end

      if (adv_wrap || limit_hit) begin
         adv_item  = done_item();
         adv_phase = PH_IDLE;
      end else begin
         adv_item  = read_item(adv_bus, adv_slot, adv_func, OFFSET_ID);
         adv_phase = PH_ID;
      end
   end

   // next state and results of the accepted transaction
   always_comb begin
      phase_in = phase_ff;
      bus_in   = bus_ff;
      slot_in  = slot_ff;
      func_in  = func_ff;
      held_in  = held_ff;
      found_in = found_ff;
      item0    = done_item();
      item1    = done_item();
      push_cnt = 2'd0;

      if (req_accept) begin
         if (req_chan.req_type == REQ_START) begin
            bus_in   = '0;
            slot_in  = 5'd0;
            func_in  = 3'd0;
            held_in  = 32'd0;
            found_in = 8'd0;
            push_cnt = 2'd1;
            if (max_devices_ff == 8'd0) begin
               phase_in = PH_IDLE;
            end else begin
               item0    = read_item('0, 5'd0, 3'd0, OFFSET_ID);
               phase_in = PH_ID;
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  // stray response: drop
               end
               PH_ID: begin
                  push_cnt = 2'd1;
                  if (req_chan.read_data[15:0] == VENDOR_NONE) begin
                     bus_in   = adv_bus;
                     slot_in  = adv_slot;
                     func_in  = adv_func;
                     item0    = adv_item;
                     phase_in = adv_phase;
                  end else begin
                     held_in  = req_chan.read_data;
                     item0    = read_item(bus_ff, slot_ff, func_ff, OFFSET_CLASS);
                     phase_in = PH_CLASS;
                  end
               end
               PH_CLASS: begin
                  push_cnt         = 2'd2;
                  found_in         = found_inc;
                  item0            = '0;
                  item0.kind       = KIND_RECORD;
                  item0.bus_num    = bus_field(bus_ff);
                  item0.slot_num   = slot_ff;
                  item0.func_num   = func_ff;
                  item0.vendor_id  = held_ff[15:0];
                  item0.device_id  = held_ff[31:16];
                  item0.revision   = req_chan.read_data[7:0];
                  item0.prog_if    = req_chan.read_data[15:8];
                  item0.sub_class  = req_chan.read_data[23:16];
                  item0.class_code = req_chan.read_data[31:24];
                  if (func_ff == 3'd0) begin
                     item1    = read_item(bus_ff, slot_ff, 3'd0, OFFSET_HDR);
                     phase_in = PH_HDR;
                  end else if (limit_hit) begin
                     phase_in = PH_IDLE;
                  end else begin
                     bus_in   = adv_bus;
                     slot_in  = adv_slot;
                     func_in  = adv_func;
                     item1    = adv_item;
                     phase_in = adv_phase;
                  end
               end
               PH_HDR: begin
                  push_cnt = 2'd1;
                  if (limit_hit) begin
                     phase_in = PH_IDLE;
                  end else begin
                     bus_in   = adv_bus;
                     slot_in  = adv_slot;
                     func_in  = adv_func;
                     item0    = adv_item;
                     phase_in = adv_phase;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (push_cnt == 2'd2) begin
         item1.last = 1'b1;
      end else begin
         item0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bus_ff         <= '0;
         slot_ff        <= 5'd0;
         func_ff        <= 3'd0;
         held_ff        <= 32'd0;
         found_ff       <= 8'd0;
         max_devices_ff <= MAX_DEVICES_RESET;
      end else begin
         phase_ff <= phase_in;
         bus_ff   <= bus_in;
         slot_ff  <= slot_in;
         func_ff  <= func_in;
         held_ff  <= held_in;
         found_ff <= found_in;
         if (csr_write_enable) begin
            max_devices_ff <= csr_write_data;
         end
      end
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= item0;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[PTR_W'(wr_ptr_ff + PTR_W'(1))] <= item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= PTR_W'(wr_ptr_ff + PTR_W'(push_cnt));
         rd_ptr_ff <= PTR_W'(rd_ptr_ff + PTR_W'(rsp_pop));
         fill_ff   <= FILL_W'(fill_ff + FILL_W'(push_cnt) - FILL_W'(rsp_pop));
      end
   end

   assign rsp_chan.valid      = (fill_ff != '0);
   assign rsp_chan.kind       = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.bus_num    = fifo_ff[rd_ptr_ff].bus_num;
   assign rsp_chan.slot_num   = fifo_ff[rd_ptr_ff].slot_num;
   assign rsp_chan.func_num   = fifo_ff[rd_ptr_ff].func_num;
   assign rsp_chan.reg_offset = fifo_ff[rd_ptr_ff].reg_offset;
   assign rsp_chan.vendor_id  = fifo_ff[rd_ptr_ff].vendor_id;
   assign rsp_chan.device_id  = fifo_ff[rd_ptr_ff].device_id;
   assign rsp_chan.revision   = fifo_ff[rd_ptr_ff].revision;
   assign rsp_chan.prog_if    = fifo_ff[rd_ptr_ff].prog_if;
   assign rsp_chan.sub_class  = fifo_ff[rd_ptr_ff].sub_class;
   assign rsp_chan.class_code = fifo_ff[rd_ptr_ff].class_code;
   assign rsp_chan.last       = fifo_ff[rd_ptr_ff].last;

   `PCSS_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(FIFO_DEPTH), "result buffer overflow")
   `PCSS_ASSERT_IMPL(a_idle_drop, clock, reset, req_accept && req_chan.req_type == REQ_RESPONSE && phase_ff == PH_IDLE, push_cnt == 2'd0, "response while idle produced results")
   `PCSS_ASSERT_NEXT(a_class_two, clock, reset, req_accept && req_chan.req_type == REQ_RESPONSE && phase_ff == PH_CLASS, fill_ff >= FILL_W'(2), "class response did not queue record and follow-up")
   `PCSS_ASSERT_IMPL(a_done_clean, clock, reset, rsp_chan.valid && rsp_chan.kind == KIND_DONE, rsp_chan.bus_num == 3'd0 && rsp_chan.slot_num == 5'd0 && rsp_chan.vendor_id == 16'd0, "scan done carries position data")

endmodule

@@ sim/pcss_scan_checker.sv @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - scan checker
// Watches the request, response and CSR ports. It keeps its own copy of the
// bus/slot/function walk, predicts every response transaction and compares
// the responses field by field in order.
// ---------------------------------------------------------------------------
module pcss_scan_checker (
   input  logic       clock,
   input  logic       reset,
   pcss_req_if        req_mon,
   pcss_rsp_if        rsp_mon,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         pending_count,
   output int         record_count,
   output int         done_count,
   output logic       scan_busy
);
   import pcss_pkg::*;

   logic [7:0]   device_limit;
   phase_type    walk_phase;
   int           walk_bus;
   logic [4:0]   walk_slot;
   logic [2:0]   walk_func;
   logic [31:0]  id_word;
   logic [7:0]   found_devices;
   rsp_item_type expected_rsp_q[$];

   function automatic void queue_read(input logic [2:0] func, input logic [7:0] offset);
      rsp_item_type item;
      item            = '0;
      item.kind       = KIND_READ;
      item.bus_num    = 3'(walk_bus);
      item.slot_num   = walk_slot;
      item.func_num   = func;
      item.reg_offset = offset;
      expected_rsp_q.push_back(item);
   endfunction

   function automatic void queue_done();
      rsp_item_type item;
      item       = '0;
      item.kind  = KIND_DONE;
      walk_phase = PH_IDLE;
      expected_rsp_q.push_back(item);
   endfunction

   // ID read for the current position, or scan done once the limit is hit
   function automatic void issue_id_read();
      if (found_devices >= device_limit) begin
         queue_done();
      end else begin
         queue_read(walk_func, OFFSET_ID);
         walk_phase = PH_ID;
      end
   endfunction

   function automatic void next_position(input logic skip_slot);
      if (!skip_slot && walk_func != FUNC_LAST) begin
         walk_func = walk_func + 3'd1;
      end else begin
         walk_func = '0;
         if (walk_slot == SLOT_LAST) begin
            walk_slot = '0;
            if (walk_bus == NUM_BUSES - 1) begin
               walk_bus = 0;
               queue_done();
               return;
            end
            walk_bus++;
         end else begin
            walk_slot = walk_slot + 5'd1;
         end
      end
      issue_id_read();
   endfunction

   function automatic void scan_step(input logic req_type, input logic [31:0] data);
      rsp_item_type item;
      int           before_cnt;
      before_cnt = expected_rsp_q.size();
      if (req_type == REQ_START) begin
         walk_bus      = 0;
         walk_slot     = '0;
         walk_func     = '0;
         id_word       = '0;
         found_devices = '0;
         issue_id_read();
      end else begin
         case (walk_phase)
            PH_ID: begin
               if (data[15:0] == VENDOR_NONE) begin
                  next_position(walk_func == 3'd0);
               end else begin
                  id_word = data;
                  queue_read(walk_func, OFFSET_CLASS);
                  walk_phase = PH_CLASS;
               end
            end
            PH_CLASS: begin
               item            = '0;
               item.kind       = KIND_RECORD;
               item.bus_num    = 3'(walk_bus);
               item.slot_num   = walk_slot;
               item.func_num   = walk_func;
               item.vendor_id  = id_word[15:0];
               item.device_id  = id_word[31:16];
               item.revision   = data[7:0];
               item.prog_if    = data[15:8];
               item.sub_class  = data[23:16];
               item.class_code = data[31:24];
               expected_rsp_q.push_back(item);
               found_devices = found_devices + 8'd1;
               if (walk_func == 3'd0) begin
                  queue_read(3'd0, OFFSET_HDR);
                  walk_phase = PH_HDR;
               end else if (found_devices >= device_limit) begin
                  queue_done();
               end else begin
                  next_position(1'b0);
               end
            end
            PH_HDR: begin
               if (found_devices >= device_limit) begin
                  queue_done();
               end else begin
                  next_position(!data[MULTI_FUNC_BIT]);
               end
            end
            default: begin
               // response while idle: drop
            end
         endcase
      end
      if (expected_rsp_q.size() > before_cnt) begin
         expected_rsp_q[expected_rsp_q.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void flag_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         device_limit  = MAX_DEVICES_RESET;
         walk_phase    = PH_IDLE;
         walk_bus      = 0;
         walk_slot     = '0;
         walk_func     = '0;
         id_word       = '0;
         found_devices = '0;
         expected_rsp_q.delete();
         fail_count    = 0;
         record_count  = 0;
         done_count    = 0;
      end else begin
         if (csr_write_enable) begin
            device_limit = csr_write_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind       = kind_type'(rsp_mon.kind);
            got.bus_num    = rsp_mon.bus_num;
            got.slot_num   = rsp_mon.slot_num;
            got.func_num   = rsp_mon.func_num;
            got.reg_offset = rsp_mon.reg_offset;
            got.vendor_id  = rsp_mon.vendor_id;
            got.device_id  = rsp_mon.device_id;
            got.revision   = rsp_mon.revision;
            got.prog_if    = rsp_mon.prog_if;
            got.sub_class  = rsp_mon.sub_class;
            got.class_code = rsp_mon.class_code;
            got.last       = rsp_mon.last;
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response transaction: kind 0x%0h", got.kind);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.kind == KIND_RECORD) record_count++;
               if (want.kind == KIND_DONE) done_count++;
               if (got.kind !== want.kind) flag_field("kind", want.kind, got.kind);
               if (got.bus_num !== want.bus_num)
                  flag_field("bus_num", want.bus_num, got.bus_num);
               if (got.slot_num !== want.slot_num)
                  flag_field("slot_num", want.slot_num, got.slot_num);
               if (got.func_num !== want.func_num)
                  flag_field("func_num", want.func_num, got.func_num);
               if (got.reg_offset !== want.reg_offset)
                  flag_field("reg_offset", want.reg_offset, got.reg_offset);
               if (got.vendor_id !== want.vendor_id)
                  flag_field("vendor_id", want.vendor_id, got.vendor_id);
               if (got.device_id !== want.device_id)
                  flag_field("device_id", want.device_id, got.device_id);
               if (got.revision !== want.revision)
                  flag_field("revision", want.revision, got.revision);
               if (got.prog_if !== want.prog_if)
                  flag_field("prog_if", want.prog_if, got.prog_if);
               if (got.sub_class !== want.sub_class)
                  flag_field("sub_class", want.sub_class, got.sub_class);
               if (got.class_code !== want.class_code)
                  flag_field("class_code", want.class_code, got.class_code);
               if (got.last !== want.last) flag_field("last", want.last, got.last);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            scan_step(req_mon.req_type, req_mon.read_data);
         end
      end
      pending_count = expected_rsp_q.size();
      scan_busy     = (walk_phase != PH_IDLE);
   end

endmodule

@@ sim/tb_pci_config_scan_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// PCI configuration scan sequencer - testbench top
// Drives start and read-response transactions into the sequencer, backs up
// the response channel at random, and reprograms the device limit between
// phases. The scan checker beside the block predicts and compares; this
// module gives the verdict.
// ---------------------------------------------------------------------------
module tb_pci_config_scan_sequencer_top;
   import pcss_pkg::*;

   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES = 6;
   localparam int NUM_PHASES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;

   int   fail_count;
   int   pending_count;
   int   record_count;
   int   done_count;
   logic scan_busy;

   int req_idle_pct = 18;
   int rsp_idle_pct = 18;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int items_sent = 0;
   int limits_used = 0;

   pcss_req_if req_chan ();
   pcss_rsp_if rsp_chan ();

   pci_config_scan_sequencer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pcss_scan_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .record_count     (record_count),
      .done_count       (done_count),
      .scan_busy        (scan_busy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_START;
      req_chan.read_data = '0;
      rsp_chan.ready     = 1'b0;
   end

   // response sink: random back-pressure, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left == 0 && holds_served < holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // called and returns at a falling edge; valid stays up for a following item
   task automatic send_item(input req_kind_type kind, input logic [31:0] data);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.req_type  = kind;
      req_chan.read_data = data;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_count(input req_kind_type kind, input logic [31:0] data);
      send_item(kind, data);
      items_sent++;
   endtask

   // hold the input until every predicted response has come out
   task automatic drain();
      req_chan.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      limits_used++;
   endtask

   function automatic logic [31:0] scan_word(input int none_pct);
      logic [31:0] word;
      word = $urandom();
      if ($urandom_range(99) < none_pct) word[15:0] = VENDOR_NONE;
      return word;
   endfunction

   task automatic run_phase(input int count, input int start_pct, input int none_pct,
                            input int hold_at, input int pause_at);
      int sent;
      sent = 0;
      while (sent < count) begin
         if (sent == hold_at) holds_asked++;
         if (sent == pause_at) drain();
         if (!scan_busy) begin
            // mostly restart; now and then poke the idle block with a response
            if ($urandom_range(9) == 0) begin
               send_item(REQ_RESPONSE, $urandom());
            end else begin
               send_count(REQ_START, $urandom());
               sent++;
            end
         end else if ($urandom_range(99) < start_pct) begin
            send_count(REQ_START, $urandom());
            sent++;
         end else begin
            send_count(REQ_RESPONSE, scan_word(none_pct));
            sent++;
         end
      end
   endtask

   initial begin
      int phase_limit[NUM_PHASES];
      int phase_items[NUM_PHASES];
      int phase_start[NUM_PHASES];
      int phase_none[NUM_PHASES];

      phase_limit = '{255, 1, 0, 7, 255, 128, 0, 255};
      phase_items = '{110, 80, 30, 120, 450, 120, 100, 60};
      phase_start = '{3, 2, 0, 3, 0, 2, 3, 4};
      phase_none  = '{40, 30, 40, 35, 93, 45, 40, 50};
      phase_limit[6] = $urandom_range(2, 40);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // response while idle, then a short scan at the reset limit
      send_item(REQ_RESPONSE, 32'hA5A5_5A5A);
      send_count(REQ_START, 32'hFFFF_FFFF);
      send_count(REQ_RESPONSE, 32'hFFFF_FFFF);
      send_count(REQ_RESPONSE, 32'h1234_5678);
      send_count(REQ_RESPONSE, 32'hFFFF_FFFF);
      send_count(REQ_RESPONSE, 32'h0080_0000);
      send_count(REQ_RESPONSE, 32'h0000_0000);
      send_count(REQ_RESPONSE, 32'h0000_0000);
      send_count(REQ_RESPONSE, 32'h0000_FFFF);
      send_count(REQ_RESPONSE, 32'hFFFF_0000);
      // restart mid-scan
      send_count(REQ_START, 32'h0000_0000);
      send_count(REQ_RESPONSE, 32'hBEEF_1AF4);
      send_count(REQ_RESPONSE, 32'h0C03_3001);
      send_count(REQ_RESPONSE, 32'hFF7F_FFFF);

      // zero limit: start answers with done only
      write_limit(8'd0);
      send_count(REQ_START, 32'h0000_0000);

      // limit hit on function 0: header read still goes out, then done
      write_limit(8'd1);
      send_count(REQ_START, 32'h0000_0000);
      send_count(REQ_RESPONSE, 32'h5555_AAAA);
      send_count(REQ_RESPONSE, 32'h0102_0304);
      send_count(REQ_RESPONSE, 32'h0080_0000);

      // limit hit on a later function: record then done
      write_limit(8'd2);
      send_count(REQ_START, 32'h0000_0000);
      send_count(REQ_RESPONSE, 32'h1111_2222);
      send_count(REQ_RESPONSE, 32'h3333_4444);
      send_count(REQ_RESPONSE, 32'h0080_0000);
      send_count(REQ_RESPONSE, 32'h5555_6666);
      send_count(REQ_RESPONSE, 32'h7777_8888);

      // lower the limit while a scan is under way
      write_limit(8'd255);
      send_count(REQ_START, 32'h0000_0000);
      send_count(REQ_RESPONSE, 32'h9999_AAAA);
      send_count(REQ_RESPONSE, 32'hBBBB_CCCC);
      send_count(REQ_RESPONSE, 32'h0080_0000);
      write_limit(8'd1);
      send_count(REQ_RESPONSE, 32'hFFFF_FFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(8'(phase_limit[p]));
         if (p == 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_phase(phase_items[p], phase_start[p], phase_none[p],
                   (p == 3) ? 40 : -1, (p == 5) ? 60 : -1);
         req_idle_pct = 18;
         rsp_idle_pct = 18;
      end

      drain();
      repeat (20) @(negedge clock);

      $display("Run covered %0d input transactions over %0d device limit settings,",
               items_sent, limits_used);
      $display("with %0d device records and %0d scan-done results checked.",
               record_count, done_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/pcss_pkg.sv
hdl/pcss_req_if.sv
hdl/pcss_rsp_if.sv
hdl/pci_config_scan_sequencer_top.sv
sim/pcss_scan_checker.sv
sim/tb_pci_config_scan_sequencer_top.sv
